### design/mrtu_pkg.sv
// shared types and constants for the modbus rtu slave frame engine
package mrtu_pkg;

   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_EOF  = 2'd1;
   localparam logic [1:0] FUNC_LOAD = 2'd2;

   localparam logic [7:0] FC_READ_HOLD   = 8'h03;
   localparam logic [7:0] FC_READ_INPUT  = 8'h04;
   localparam logic [7:0] FC_WRITE_ONE   = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI = 8'h10;

   localparam logic [7:0] EXC_FUNCTION = 8'd1;
   localparam logic [7:0] EXC_ADDRESS  = 8'd2;
   localparam logic [7:0] EXC_VALUE    = 8'd3;

   localparam logic [7:0]  EXC_FLAG    = 8'h80;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [16:0] READ_MAX    = 17'd125;
   localparam logic [16:0] WRITE_MAX   = 17'd123;

   localparam logic [1:0] CSR_SLAVE_ADDRESS = 2'd0;

   // transmit byte source
   typedef enum logic [2:0] {
      SRC_ADDR,
      SRC_FC,
      SRC_FC_EXC,
      SRC_CODE,
      SRC_COUNT,
      SRC_FRAME,
      SRC_REG_HI,
      SRC_REG_LO
   } src_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK_RD,
      ST_CHECK_WAIT,
      ST_CHECK_CRC,
      ST_HDR_RD,
      ST_HDR_WAIT,
      ST_DECIDE,
      ST_WRITE_RD,
      ST_WRITE_WAIT,
      ST_WRITE_APPLY,
      ST_TX_PREP,
      ST_TX_WAIT,
      ST_TX_CRC,
      ST_TX_SEND,
      ST_CRC_LO,
      ST_CRC_HI
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic        clear_len;
      logic        crc_init;
      logic        crc_feed_rd;
      logic        crc_feed_tx;
      logic        rd_req;
      logic [8:0]  rd_addr;
      logic        cap_hdr;
      logic        hold_wr;
      logic [4:0]  hold_idx;
      logic [4:0]  reg_idx;
      src_type     src;
      logic [7:0]  exc_code;
      logic        tx_load;
      logic        crc_lo;
      logic        crc_hi;
      logic        tx_last;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [8:0]  frame_len;
      logic [7:0]  addr_byte;
      logic [7:0]  fc_byte;
      logic [15:0] start;
      logic [15:0] qty;
      logic [7:0]  bc;
      logic        crc_ok;
      logic        tx_full;
   } stat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
      logic [15:0] c;
      c = c_in ^ {8'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

endpackage

### design/mrtu_datapath.sv
// datapath: frame store, register stores, crc unit and transmit register
module mrtu_datapath
   import mrtu_pkg::*;
#(
   parameter int FRAME_BYTES  = 256,
   parameter int HOLDING_REGS = 16,
   parameter int INPUT_REGS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_take,
   input  logic [1:0]  in_func,
   input  logic [7:0]  in_byte,
   input  logic [3:0]  in_index,
   input  logic [15:0] in_value,
   input  logic [7:0]  slave_addr,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        out_ready,
   output logic        out_valid,
   output logic [7:0]  out_byte,
   output logic        out_last
);
   localparam int AW = $clog2(FRAME_BYTES);

   logic [7:0]  frame_mem [FRAME_BYTES];
   logic [7:0]  rd_data_ff;
   logic [8:0]  len_ff, len_in;
   logic [15:0] hold_ff [HOLDING_REGS];
   logic [15:0] inp_ff  [INPUT_REGS];
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  addr_ff, fc_ff, bc_ff;
   logic [15:0] start_ff, qty_ff;
   logic [7:0]  rx_crc_lo_ff, rx_crc_hi_ff;
   logic [7:0]  prev_ff;
   logic [15:0] reg_word;
   logic [7:0]  tx_sel;
   logic        valid_ff;
   logic [7:0]  tx_byte_ff;
   logic        tx_last_ff;

   // frame store write and registered read
   always_ff @(posedge clock) begin
      if (in_take && in_func == FUNC_BYTE && len_ff < 9'(FRAME_BYTES))
         frame_mem[len_ff[AW-1:0]] <= in_byte;
      if (cmd.rd_req) rd_data_ff <= frame_mem[cmd.rd_addr[AW-1:0]];
   end

   // frame length
   always_comb begin
      len_in = len_ff;
      if (cmd.clear_len) len_in = '0;
      else if (in_take && in_func == FUNC_BYTE && len_ff < 9'(FRAME_BYTES))
         len_in = len_ff + 9'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) len_ff <= '0;
      else len_ff <= len_in;
   end

   // register stores
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOLDING_REGS; i++) hold_ff[i] <= '0;
         for (int i = 0; i < INPUT_REGS; i++) inp_ff[i] <= '0;
      end else begin
         if (cmd.hold_wr)
            for (int i = 0; i < HOLDING_REGS; i++)
               if (cmd.hold_idx == 5'(i)) hold_ff[i] <= {prev_ff, rd_data_ff};
         if (in_take && in_func == FUNC_LOAD)
            for (int i = 0; i < INPUT_REGS; i++)
               if (in_index == 4'(i)) inp_ff[i] <= in_value;
      end
   end

   // header capture, one frame byte per strobe by address
   always_ff @(posedge clock) begin
      prev_ff <= rd_data_ff;
      if (cmd.cap_hdr) begin
         case (cmd.rd_addr)
            9'd0: addr_ff <= rd_data_ff;
            9'd1: fc_ff <= rd_data_ff;
            9'd2: start_ff[15:8] <= rd_data_ff;
            9'd3: start_ff[7:0] <= rd_data_ff;
            9'd4: qty_ff[15:8] <= rd_data_ff;
            9'd5: qty_ff[7:0] <= rd_data_ff;
            9'd6: bc_ff <= rd_data_ff;
            default: ;
         endcase
         if (cmd.rd_addr == len_ff - 9'd2) rx_crc_lo_ff <= rd_data_ff;
         if (cmd.rd_addr == len_ff - 9'd1) rx_crc_hi_ff <= rd_data_ff;
      end
   end

   // register word selection
   always_comb begin
      reg_word = '0;
      if (fc_ff == FC_READ_INPUT) begin
         for (int i = 0; i < INPUT_REGS; i++)
            if (cmd.reg_idx == 5'(i)) reg_word = inp_ff[i];
      end else begin
         for (int i = 0; i < HOLDING_REGS; i++)
            if (cmd.reg_idx == 5'(i)) reg_word = hold_ff[i];
      end
   end

   // transmit byte selection
   always_comb begin
      case (cmd.src)
         SRC_ADDR:   tx_sel = slave_addr;
         SRC_FC:     tx_sel = fc_ff;
         SRC_FC_EXC: tx_sel = fc_ff | EXC_FLAG;
         SRC_CODE:   tx_sel = cmd.exc_code;
         SRC_COUNT:  tx_sel = {qty_ff[6:0], 1'b0};
         SRC_FRAME:  tx_sel = rd_data_ff;
         SRC_REG_HI: tx_sel = reg_word[15:8];
         SRC_REG_LO: tx_sel = reg_word[7:0];
         default:    tx_sel = '0;
      endcase
   end

   // crc unit, one byte per cycle
   always_comb begin
      crc_in = crc_ff;
      if (cmd.crc_init) crc_in = CRC_INIT;
      else if (cmd.crc_feed_rd) crc_in = crc_byte(crc_ff, rd_data_ff);
      else if (cmd.crc_feed_tx) crc_in = crc_byte(crc_ff, tx_sel);
   end

   always_ff @(posedge clock) crc_ff <= crc_in;

   // output register
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (cmd.tx_load || cmd.crc_lo || cmd.crc_hi) valid_ff <= 1'b1;
      else if (out_ready) valid_ff <= 1'b0;
      if (cmd.tx_load) tx_byte_ff <= tx_sel;
      else if (cmd.crc_lo) tx_byte_ff <= crc_ff[7:0];
      else if (cmd.crc_hi) tx_byte_ff <= crc_ff[15:8];
      if (cmd.tx_load || cmd.crc_lo || cmd.crc_hi) tx_last_ff <= cmd.tx_last;
   end

   assign out_valid = valid_ff;
   assign out_byte  = tx_byte_ff;
   assign out_last  = tx_last_ff;

   assign stat.frame_len = len_ff;
   assign stat.addr_byte = addr_ff;
   assign stat.fc_byte   = fc_ff;
   assign stat.start     = start_ff;
   assign stat.qty       = qty_ff;
   assign stat.bc        = bc_ff;
   assign stat.crc_ok    = (crc_ff == {rx_crc_hi_ff, rx_crc_lo_ff});
   assign stat.tx_full   = valid_ff && !out_ready;
endmodule

### design/mrtu_control.sv
// controller: frame checking, request decode and response sequencing
module mrtu_control
   import mrtu_pkg::*;
#(
   parameter int HOLDING_REGS = 16,
   parameter int INPUT_REGS   = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       eof_take,
   input  logic [7:0] slave_addr,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy
);
   // response kinds
   localparam logic [1:0] K_EXC  = 2'd0;
   localparam logic [1:0] K_READ = 2'd1;
   localparam logic [1:0] K_ECHO = 2'd2;
   localparam logic [1:0] K_WMUL = 2'd3;

   state_type   state_ff, state_in;
   logic [8:0]  idx_ff, idx_in;
   logic [8:0]  tx_len_ff, tx_len_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  code_ff, code_in;
   logic        quiet_ff, quiet_in;
   logic [16:0] last_reg;
   logic [16:0] qty17;
   logic [8:0]  rd_pos;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
      idx_ff    <= idx_in;
      tx_len_ff <= tx_len_in;
      kind_ff   <= kind_in;
      code_ff   <= code_in;
      quiet_ff  <= quiet_in;
   end

   assign qty17    = {1'b0, stat.qty};
   assign last_reg = {1'b0, stat.start} + qty17 - 17'd1;

   // byte position within the response, relative to idx
   always_comb begin
      rd_pos = idx_ff;
      case (kind_ff)
         K_ECHO:  rd_pos = idx_ff;
         K_WMUL:  rd_pos = idx_ff;
         default: rd_pos = idx_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      tx_len_in = tx_len_ff;
      kind_in   = kind_ff;
      code_in   = code_ff;
      quiet_in  = quiet_ff;
      cmd       = '0;
      cmd.src   = SRC_ADDR;
      cmd.exc_code = code_ff;
      cmd.rd_addr = idx_ff;
      cmd.reg_idx = 5'(({1'b0, stat.start} + {8'd0, ((rd_pos - 9'd3) >> 1)}));
      cmd.hold_idx = 5'(stat.start + 16'((idx_ff - 9'd8) >> 1));
      busy = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (eof_take) begin
               if (stat.frame_len < 9'd4) begin
                  cmd.clear_len = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.crc_init = 1'b1;
                  state_in = ST_CHECK_RD;
               end
            end
         end
         // walk the whole frame: header capture and crc over all but last two
         ST_CHECK_RD: begin
            cmd.rd_req = 1'b1;
            state_in = ST_CHECK_WAIT;
         end
         ST_CHECK_WAIT: begin
            cmd.cap_hdr = 1'b1;
            if (idx_ff < stat.frame_len - 9'd2) cmd.crc_feed_rd = 1'b1;
            if (idx_ff + 9'd1 < stat.frame_len) begin
               idx_in = idx_ff + 9'd1;
               state_in = ST_CHECK_RD;
            end else state_in = ST_CHECK_CRC;
         end
         ST_CHECK_CRC: begin
            quiet_in = (stat.addr_byte == 8'd0);
            if ((stat.addr_byte != 8'd0 && stat.addr_byte != slave_addr) || !stat.crc_ok) begin
               cmd.clear_len = 1'b1;
               state_in = ST_IDLE;
            end else state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = ST_TX_PREP;
            idx_in = '0;
            case (stat.fc_byte)
               FC_READ_HOLD, FC_READ_INPUT: begin
                  if (stat.frame_len < 9'd8) state_in = ST_HDR_RD;
                  else if (qty17 < 17'd1 || qty17 > READ_MAX) begin
                     kind_in = K_EXC;
                     code_in = EXC_VALUE;
                  end else if (last_reg >= ((stat.fc_byte == FC_READ_HOLD) ?
                           17'(HOLDING_REGS) : 17'(INPUT_REGS))) begin
                     kind_in = K_EXC;
                     code_in = EXC_ADDRESS;
                  end else kind_in = K_READ;
                  tx_len_in = (kind_in == K_READ) ? 9'd3 + {qty17[7:0], 1'b0} : 9'd3;
               end
               FC_WRITE_ONE: begin
                  if (stat.frame_len < 9'd8) state_in = ST_HDR_RD;
                  else if ({1'b0, stat.start} >= 17'(HOLDING_REGS)) begin
                     kind_in = K_EXC;
                     code_in = EXC_ADDRESS;
                  end else begin
                     kind_in = K_ECHO;
                     idx_in = 9'd5;
                     state_in = ST_WRITE_RD;
                  end
                  tx_len_in = (kind_in == K_ECHO) ? 9'd6 : 9'd3;
               end
               FC_WRITE_MULTI: begin
                  if (stat.frame_len < 9'd9) state_in = ST_HDR_RD;
                  else if (qty17 < 17'd1 || qty17 > WRITE_MAX ||
                           {9'd0, stat.bc} != {qty17[15:0], 1'b0}) begin
                     kind_in = K_EXC;
                     code_in = EXC_VALUE;
                  end else if (last_reg >= 17'(HOLDING_REGS)) begin
                     kind_in = K_EXC;
                     code_in = EXC_ADDRESS;
                  end else if (stat.frame_len < 9'd9 + {1'b0, stat.bc}) begin
                     kind_in = K_EXC;
                     code_in = EXC_VALUE;
                  end else begin
                     kind_in = K_WMUL;
                     idx_in = 9'd8;
                     state_in = ST_WRITE_RD;
                  end
                  tx_len_in = (kind_in == K_WMUL) ? 9'd6 : 9'd3;
               end
               default: begin
                  kind_in = K_EXC;
                  code_in = EXC_FUNCTION;
                  tx_len_in = 9'd3;
               end
            endcase
         end
         // short request: drop silently
         ST_HDR_RD: begin
            cmd.clear_len = 1'b1;
            state_in = ST_IDLE;
         end
         ST_HDR_WAIT: begin
            state_in = ST_IDLE;
         end
         // register writes: read low byte at idx, high byte was at idx-1
         ST_WRITE_RD: begin
            cmd.rd_addr = idx_ff - 9'd1;
            cmd.rd_req = 1'b1;
            state_in = ST_WRITE_WAIT;
         end
         ST_WRITE_WAIT: begin
            cmd.rd_addr = idx_ff;
            cmd.rd_req = 1'b1;
            state_in = ST_WRITE_APPLY;
         end
         ST_WRITE_APPLY: begin
            cmd.hold_wr = 1'b1;
            if (kind_ff == K_ECHO) cmd.hold_idx = stat.start[4:0];
            if (kind_ff == K_WMUL && idx_ff + 9'd2 < 9'd7 + {stat.qty[7:0], 1'b0}) begin
               idx_in = idx_ff + 9'd2;
               state_in = ST_WRITE_RD;
            end else begin
               idx_in = '0;
               state_in = ST_TX_PREP;
            end
         end
         // response: compute byte, feed crc, send
         ST_TX_PREP: begin
            if (quiet_ff) begin
               cmd.clear_len = 1'b1;
               state_in = ST_IDLE;
            end else begin
               if (idx_ff == 9'd0) cmd.crc_init = 1'b1;
               cmd.rd_req = 1'b1;
               state_in = ST_TX_WAIT;
            end
         end
         ST_TX_WAIT: begin
            state_in = ST_TX_SEND;
         end
         ST_TX_SEND: begin
            if (idx_ff == 9'd0) cmd.src = SRC_ADDR;
            else case (kind_ff)
               K_EXC:  cmd.src = (idx_ff == 9'd1) ? SRC_FC_EXC : SRC_CODE;
               K_READ: cmd.src = (idx_ff == 9'd1) ? SRC_FC :
                                 (idx_ff == 9'd2) ? SRC_COUNT :
                                 (idx_ff[0]) ? SRC_REG_HI : SRC_REG_LO;
               K_ECHO: cmd.src = SRC_FRAME;
               K_WMUL: cmd.src = (idx_ff == 9'd1) ? SRC_FC : SRC_FRAME;
               default: cmd.src = SRC_ADDR;
            endcase
            if (kind_ff == K_ECHO && idx_ff == 9'd1) cmd.src = SRC_FRAME;
            if (!stat.tx_full) begin
               cmd.tx_load = 1'b1;
               cmd.crc_feed_tx = 1'b1;
               if (idx_ff + 9'd1 == tx_len_ff) state_in = ST_CRC_LO;
               else begin
                  idx_in = idx_ff + 9'd1;
                  state_in = ST_TX_PREP;
               end
            end
         end
         ST_CRC_LO: begin
            if (!stat.tx_full) begin
               cmd.crc_lo = 1'b1;
               state_in = ST_CRC_HI;
            end
         end
         ST_CRC_HI: begin
            if (!stat.tx_full) begin
               cmd.crc_hi = 1'b1;
               cmd.tx_last = 1'b1;
               cmd.clear_len = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

### design/modbus_rtu_slave_frame_engine_unit.sv
// top level of the modbus rtu slave frame engine
// Usage:
//  req_ channel carries one request per handshake: a received byte, an
//  end-of-frame mark or a local input register load. rsp_ channel returns
//  the response frame one byte per handshake, rsp_tlast on the final crc byte.
//  csr_ is an apb-style port holding the station address at offset 0.
// Sequencing:
//  bytes and loads are taken while the engine is idle. An end-of-frame mark
//  walks the frame store through its single read port, with a read and a
//  wait state per stored byte, then builds the response with prep, wait and
//  send states per byte and a state of its own for each crc byte; register
//  writes run through read, wait and apply states per register. No request
//  is taken while a frame is being served.
// Reset:
//  synchronous; clears the frame length, both register stores and sets the
//  station address to 1.
// Stall:
//  a stalled receiver holds the response byte; the sequencer waits for it.
module modbus_rtu_slave_frame_engine_unit
   import mrtu_pkg::*;
#(
   parameter int FRAME_BYTES  = 256,
   parameter int HOLDING_REGS = 16,
   parameter int INPUT_REGS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: rx_byte[7:0], reg_index[11:8], reg_value[27:12], zero [31:28]
   input  logic [31:0] req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: tx_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic       busy;
   logic       take;
   logic [7:0] slave_addr_ff;
   cmd_type    cmd;
   stat_type   stat;

   assign req_tready = !busy;
   assign take = req_tvalid && req_tready;
   assign csr_pready = 1'b1;

   // station address register
   always_ff @(posedge clock) begin
      if (reset) slave_addr_ff <= 8'd1;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_SLAVE_ADDRESS)
         slave_addr_ff <= csr_pwdata[7:0];
   end

   assign csr_prdata = (csr_paddr == CSR_SLAVE_ADDRESS) ? {24'd0, slave_addr_ff} : '0;

   mrtu_control #(
      .HOLDING_REGS(HOLDING_REGS),
      .INPUT_REGS(INPUT_REGS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .eof_take(take && req_tuser == FUNC_EOF),
      .slave_addr(slave_addr_ff),
      .stat(stat),
      .cmd(cmd),
      .busy(busy)
   );

   mrtu_datapath #(
      .FRAME_BYTES(FRAME_BYTES),
      .HOLDING_REGS(HOLDING_REGS),
      .INPUT_REGS(INPUT_REGS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .in_take(take),
      .in_func(req_tuser),
      .in_byte(req_tdata[7:0]),
      .in_index(req_tdata[11:8]),
      .in_value(req_tdata[27:12]),
      .slave_addr(slave_addr_ff),
      .cmd(cmd),
      .stat(stat),
      .out_ready(rsp_tready),
      .out_valid(rsp_tvalid),
      .out_byte(rsp_tdata),
      .out_last(rsp_tlast)
   );
endmodule

### design/mrtu_checker.sv
// port-level checker for the frame engine, bound to the top level
module mrtu_port_props (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   // a stalled response byte holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response byte changed under stall");

   // no request taken while a response is still being built
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request accepted during response");

   // handshake flags are always known out of reset
   a_known: assert property (@(posedge clock) disable iff (reset)
      !$isunknown(rsp_tvalid) && !$isunknown(req_tready))
      else $error("handshake flag unknown");

   // reset leaves no response
   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");
endmodule

bind modbus_rtu_slave_frame_engine_unit mrtu_port_props u_check (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tlast(rsp_tlast)
);
